// ===== rtl/mlt_pkg.sv =====
`default_nettype none
package mlt_pkg;

  // command codes of an input word
  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_LEARN       = 3'd1,
    CMD_LOOKUP      = 3'd2,
    CMD_ADD_STATIC  = 3'd3,
    CMD_REMOVE      = 3'd4,
    CMD_REMOVE_PORT = 3'd5,
    CMD_FLUSH_DYN   = 3'd6,
    CMD_AGING_MODE  = 3'd7
  } cmd_t;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TABLE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_NORMAL_AGE  = 2'd1;
  localparam logic [1:0] CFG_FAST_AGE    = 2'd2;

  // reset values of the configuration registers
  localparam logic [10:0] RST_TABLE_LIMIT = 11'd1024;
  localparam logic [15:0] RST_NORMAL_AGE  = 16'd300;
  localparam logic [15:0] RST_FAST_AGE    = 16'd5;

  // controller to datapath commands
  typedef struct packed {
    logic clr;       // clearing pass, invalidate at sweep address
    logic accept;    // take the input word
    logic rd;        // scan read at sweep address
    logic evict;     // drop oldest dynamic entry if the table is full
    logic commit;    // final table update and result
    logic load_out;  // move result into the output register
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic addr_last;   // sweep address at last entry
    logic needs_scan;  // input command walks the table
    logic out_free;    // output register can take a word
  } ctl_sts_t;

endpackage
`default_nettype wire

// ===== rtl/mlt_ctrl.sv =====
`default_nettype none
module mlt_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire mlt_pkg::ctl_sts_t sts,
  output mlt_pkg::ctl_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_DRAIN  = 7'b0001000,
    S_EVICT  = 7'b0010000,
    S_COMMIT = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.addr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.needs_scan ? S_SCAN : S_OUT;
        end
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (sts.addr_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_EVICT;
      S_EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/mlt_dpath.sv =====
`default_nettype none
module mlt_dpath #(
  parameter int TABLE_DEPTH = 1024,
  parameter int PORT_COUNT  = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_valid,
  input  wire  [1:0]                           cfg_index,
  input  wire  [15:0]                          cfg_data,
  input  wire  [2:0]                           in_command,
  input  wire  [47:0]                          in_mac_address,
  input  wire  [3:0]                           in_port,
  input  wire  [PORT_COUNT-1:0]                in_port_mask,
  input  wire  [1:0]                           in_spec_code,
  input  wire                                  in_fast_aging,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic                                 out_hit,
  output logic [PORT_COUNT-1:0]                out_ports_out,
  output logic [1:0]                           out_spec_out,
  output logic [1:0]                           out_status,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     out_entry_count,
  input  wire mlt_pkg::ctl_cmd_t               cmd,
  output mlt_pkg::ctl_sts_t                    sts
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic                  v;
    logic [47:0]           key;
    logic [PORT_COUNT-1:0] ports;
    logic                  stat;
    logic [1:0]            spec;
    logic [31:0]           tim;
  } ent_t;

  // table storage
  ent_t mem [TABLE_DEPTH];

  // configuration and global state
  logic [10:0] tbl_limit_r;
  logic [15:0] age_norm_r, age_fast_r;
  logic [31:0] now_r;
  logic        fast_r;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // latched input word
  mlt_pkg::cmd_t         cmd_r;
  logic [47:0]           key_r;
  logic [3:0]            port_r;
  logic [PORT_COUNT-1:0] pmask_r;
  logic [1:0]            spec_r;

  // sweep and scan trackers
  logic [AW-1:0] addr_r, proc_addr_r;
  logic          proc_v_r;
  ent_t          rd_data_r;
  logic          found_r;
  logic [AW-1:0] fidx_r;
  ent_t          fent_r;
  logic          ff_v_r;
  logic [AW-1:0] ff_r;
  logic          best_v_r;
  logic [AW-1:0] best_idx_r;
  logic [31:0]   best_age_r;
  logic [47:0]   best_key_r;
  logic          evicted_r;

  // result registers
  logic                  res_hit_r, res_hit_nxt;
  logic [PORT_COUNT-1:0] res_ports_r, res_ports_nxt;
  logic [1:0]            res_spec_r, res_spec_nxt;
  logic [1:0]            res_status_r, res_status_nxt;
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [PORT_COUNT-1:0] out_ports_r;
  logic [1:0]            out_spec_r, out_status_r;
  logic [CW-1:0]         out_cnt_r;

  // derived values
  logic [31:0]           lim32, eff_lim, age_e, age_f;
  logic                  aged_e, aged_f, full, is_learn, is_ins, better;
  logic [PORT_COUNT-1:0] pbit;
  logic [AW-1:0]         slot;
  ent_t                  e, wd;
  logic                  we;
  logic [AW-1:0]         wa;
  logic                  scan_drop, ev_cond;

  assign lim32   = {16'd0, (fast_r ? age_fast_r : age_norm_r)};
  assign eff_lim = (tbl_limit_r == 11'd0 || 32'(tbl_limit_r) > 32'(TABLE_DEPTH)) ?
                   32'(TABLE_DEPTH) : 32'(tbl_limit_r);
  assign full    = 32'(cnt_r) >= eff_lim;
  assign pbit    = (32'(port_r) < 32'(PORT_COUNT)) ?
                   ({{(PORT_COUNT-1){1'b0}}, 1'b1} << port_r) : '0;
  assign e       = rd_data_r;
  assign age_e   = now_r - e.tim;
  assign aged_e  = !e.stat && (age_e >= lim32);
  assign age_f   = now_r - fent_r.tim;
  assign aged_f  = !fent_r.stat && (age_f >= lim32);
  assign is_learn = (cmd_r == mlt_pkg::CMD_LEARN);
  assign is_ins  = is_learn || (cmd_r == mlt_pkg::CMD_ADD_STATIC);
  assign better  = !best_v_r || (age_e > best_age_r) ||
                   (age_e == best_age_r && e.key < best_key_r);
  assign scan_drop = proc_v_r && e.v &&
                     ((is_learn && aged_e) ||
                      (cmd_r == mlt_pkg::CMD_FLUSH_DYN && !e.stat));
  assign ev_cond = is_ins && !found_r && full && best_v_r;
  assign slot    = (evicted_r && (!ff_v_r || best_idx_r < ff_r)) ? best_idx_r : ff_r;

  assign sts.addr_last  = (addr_r == AW'(TABLE_DEPTH - 1));
  assign sts.needs_scan = !(in_command == mlt_pkg::CMD_TICK ||
                            in_command == mlt_pkg::CMD_AGING_MODE);
  assign sts.out_free   = !out_valid_r || !out_stall;

  // write port, count and result selection
  always_comb begin
    we             = 1'b0;
    wa             = proc_addr_r;
    wd             = e;
    cnt_nxt        = cnt_r;
    res_hit_nxt    = res_hit_r;
    res_ports_nxt  = res_ports_r;
    res_spec_nxt   = res_spec_r;
    res_status_nxt = res_status_r;
    priority if (cmd.clr) begin
      we = 1'b1;
      wa = addr_r;
      wd = '0;
    end else if (cmd.accept) begin
      res_hit_nxt    = 1'b0;
      res_ports_nxt  = '0;
      res_spec_nxt   = 2'd0;
      res_status_nxt = mlt_pkg::ST_OK;
    end else if (scan_drop) begin
      we      = 1'b1;
      wd.v    = 1'b0;
      cnt_nxt = cnt_r - CW'(1);
    end else if (cmd.evict && ev_cond) begin
      we      = 1'b1;
      wa      = best_idx_r;
      wd      = '0;
      cnt_nxt = cnt_r - CW'(1);
    end else if (cmd.commit) begin
      wa = fidx_r;
      wd = fent_r;
      if (found_r) begin
        res_hit_nxt = 1'b1;
        unique case (cmd_r)
          mlt_pkg::CMD_LEARN: begin
            we       = !fent_r.stat;
            wd.tim   = now_r;
            wd.ports = pbit;
          end
          mlt_pkg::CMD_ADD_STATIC: begin
            we       = 1'b1;
            wd.tim   = now_r;
            wd.ports = fent_r.ports | pmask_r;
            wd.stat  = 1'b1;
          end
          mlt_pkg::CMD_LOOKUP: begin
            if (aged_f) begin
              we             = 1'b1;
              wd.v           = 1'b0;
              cnt_nxt        = cnt_r - CW'(1);
              res_hit_nxt    = 1'b0;
              res_status_nxt = mlt_pkg::ST_MISS;
            end else begin
              res_ports_nxt = fent_r.ports;
              res_spec_nxt  = fent_r.spec;
            end
          end
          mlt_pkg::CMD_REMOVE: begin
            we      = 1'b1;
            wd.v    = 1'b0;
            cnt_nxt = cnt_r - CW'(1);
          end
          mlt_pkg::CMD_REMOVE_PORT: begin
            we       = 1'b1;
            wd.ports = fent_r.ports & ~pbit;
          end
          default: res_hit_nxt = 1'b0;
        endcase
      end else if (is_ins) begin
        if (full) begin
          res_status_nxt = mlt_pkg::ST_FULL;
        end else begin
          we       = 1'b1;
          wa       = slot;
          wd.v     = 1'b1;
          wd.key   = key_r;
          wd.ports = is_learn ? pbit : pmask_r;
          wd.stat  = !is_learn;
          wd.spec  = is_learn ? 2'd0 : spec_r;
          wd.tim   = now_r;
          cnt_nxt  = cnt_r + CW'(1);
        end
      end else if (cmd_r == mlt_pkg::CMD_LOOKUP || cmd_r == mlt_pkg::CMD_REMOVE ||
                   cmd_r == mlt_pkg::CMD_REMOVE_PORT) begin
        res_status_nxt = mlt_pkg::ST_MISS;
      end
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.rd) rd_data_r <= mem[addr_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_limit_r <= mlt_pkg::RST_TABLE_LIMIT;
      age_norm_r  <= mlt_pkg::RST_NORMAL_AGE;
      age_fast_r  <= mlt_pkg::RST_FAST_AGE;
      now_r       <= '0;
      fast_r      <= 1'b0;
      cnt_r       <= '0;
      addr_r      <= '0;
      proc_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          mlt_pkg::CFG_TABLE_LIMIT: tbl_limit_r <= cfg_data[10:0];
          mlt_pkg::CFG_NORMAL_AGE:  age_norm_r  <= cfg_data;
          mlt_pkg::CFG_FAST_AGE:    age_fast_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept && in_command == mlt_pkg::CMD_TICK) now_r <= now_r + 32'd1;
      if (cmd.accept && in_command == mlt_pkg::CMD_AGING_MODE) fast_r <= in_fast_aging;
      cnt_r    <= cnt_nxt;
      if (cmd.clr || cmd.rd) addr_r <= sts.addr_last ? '0 : addr_r + AW'(1);
      proc_v_r <= cmd.rd;
      if (cmd.load_out)        out_valid_r <= 1'b1;
      else if (!out_stall)     out_valid_r <= 1'b0;
    end
  end

  // payload: input latch, scan trackers, results
  always_ff @(posedge clk) begin
    proc_addr_r  <= addr_r;
    res_hit_r    <= res_hit_nxt;
    res_ports_r  <= res_ports_nxt;
    res_spec_r   <= res_spec_nxt;
    res_status_r <= res_status_nxt;
    if (cmd.accept) begin
      cmd_r     <= mlt_pkg::cmd_t'(in_command);
      key_r     <= in_mac_address;
      port_r    <= in_port;
      pmask_r   <= in_port_mask;
      spec_r    <= in_spec_code;
      found_r   <= 1'b0;
      ff_v_r    <= 1'b0;
      best_v_r  <= 1'b0;
      evicted_r <= 1'b0;
    end
    if (proc_v_r) begin
      if (!e.v || (is_learn && aged_e)) begin
        if (!ff_v_r) begin
          ff_v_r <= 1'b1;
          ff_r   <= proc_addr_r;
        end
      end else if (!scan_drop) begin
        if (e.key == key_r) begin
          found_r <= 1'b1;
          fidx_r  <= proc_addr_r;
          fent_r  <= e;
        end
        if (!e.stat && better) begin
          best_v_r   <= 1'b1;
          best_idx_r <= proc_addr_r;
          best_age_r <= age_e;
          best_key_r <= e.key;
        end
      end
    end
    if (cmd.evict && ev_cond) evicted_r <= 1'b1;
    if (cmd.load_out) begin
      out_hit_r    <= res_hit_r;
      out_ports_r  <= res_ports_r;
      out_spec_r   <= res_spec_r;
      out_status_r <= res_status_r;
      out_cnt_r    <= cnt_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_ports_out   = out_ports_r;
  assign out_spec_out    = out_spec_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_cnt_r;

endmodule
`default_nettype wire

// ===== rtl/mac_learning_table_with_aging.sv =====
// Flow: tick and aging_mode go from acceptance to the output state; other commands walk
//   the whole table, one entry per cycle, then pass the drain, evict and commit states.
// Input: one word at a time; in_stall stays high from acceptance until the result is
//   loaded into the output register, which waits while a stalled output word is held.
// Reset: synchronous, rst_n low. After reset a clearing pass over the table invalidates
//   every entry; no input word is taken until it ends, config writes are.
`default_nettype none
module mac_learning_table_with_aging #(
  parameter int TABLE_DEPTH = 1024,
  parameter int PORT_COUNT  = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [1:0]                       cfg_index,
  input  wire  [15:0]                      cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [2:0]                       in_command,
  input  wire  [47:0]                      in_mac_address,
  input  wire  [3:0]                       in_port,
  input  wire  [PORT_COUNT-1:0]            in_port_mask,
  input  wire  [1:0]                       in_spec_code,
  input  wire                              in_fast_aging,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_hit,
  output logic [PORT_COUNT-1:0]            out_ports_out,
  output logic [1:0]                       out_spec_out,
  output logic [1:0]                       out_status,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] out_entry_count
);

  mlt_pkg::ctl_cmd_t cmd;
  mlt_pkg::ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  mlt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PORT_COUNT  (PORT_COUNT)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_command      (in_command),
    .in_mac_address  (in_mac_address),
    .in_port         (in_port),
    .in_port_mask    (in_port_mask),
    .in_spec_code    (in_spec_code),
    .in_fast_aging   (in_fast_aging),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_ports_out   (out_ports_out),
    .out_spec_out    (out_spec_out),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .cmd             (cmd),
    .sts             (sts)
  );

  // one word in flight: an accepted word blocks the next cycle
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  // entry count never exceeds the table
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_entry_count) <= 32'(TABLE_DEPTH)))
    else $error("entry count above table depth");

  // a dropped insert never reports a hit
  a_full_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == mlt_pkg::ST_FULL) |-> !out_hit)
    else $error("full status with hit");

endmodule
`default_nettype wire
